@@ sv/lcdab_pkg.sv @@
package lcdab_pkg;

   // request field widths
   localparam int PX_W   = 9;
   localparam int PY_W   = 8;
   localparam int VAL_W  = 8;
   localparam int STAT_W = 2;
   localparam int K_W    = 8;

   // coordinate compare width (display sizes up to 1024)
   localparam int COORD_W     = 11;
   // row * width + column before trimming to the store address
   localparam int ADDR_CALC_W = 20;

   // target + shown*(k-1) stays below 2^16
   localparam int SUM_W       = 16;
   // reciprocal ceil(2^24 / k) is exact for 16-bit numerators and 8-bit k
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;
   localparam int BIG_W       = SUM_W + RECIP_W;

   localparam logic [STAT_W-1:0] DRIVE_ON      = 2'd0;
   localparam logic [STAT_W-1:0] DRIVE_OFF     = 2'd1;
   localparam logic [STAT_W-1:0] DRIVE_REVERSE = 2'd2;
   localparam logic [STAT_W-1:0] DRIVE_NONE    = 2'd3;

   localparam logic [VAL_W-1:0] VAL_MAX = 8'hFF;

   typedef struct packed {
      logic               busy;
      logic [K_W-1:0]     k;
      logic [RECIP_W-1:0] recip;
   } div_status_type;

endpackage

@@ sv/lcdab_ram.sv @@
module lcdab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lcdab_recip.sv @@
module lcdab_recip (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [lcdab_pkg::K_W-1:0]   csr_write_data,
   output lcdab_pkg::div_status_type   status
);

   localparam int RW    = lcdab_pkg::RECIP_W;
   localparam int KW    = lcdab_pkg::K_W;
   localparam int CNT_W = $clog2(RW + 1);

   logic [KW-1:0]    k_ff, k_in;
   logic [RW-1:0]    quo_ff, quo_in;
   logic [KW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [KW:0]      trial;
   logic [KW-1:0]    k_new;

   // restoring divide of (2^24 + k - 1) by k, one quotient bit per cycle;
   // dividend bits shift out of quo while quotient bits shift in
   always_comb begin
      k_in   = k_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      k_new  = (csr_write_data == '0) ? KW'(1) : csr_write_data;
      trial  = {rem_ff, quo_ff[RW-1]};
      if (csr_write_enable) begin
         k_in   = k_new;
         quo_in = (RW'(1) << lcdab_pkg::RECIP_SHIFT) + RW'(k_new - KW'(1));
         rem_in = '0;
         cnt_in = CNT_W'(RW);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (trial >= {1'b0, k_ff}) begin
            rem_in = KW'(trial - {1'b0, k_ff});
            quo_in = {quo_ff[RW-2:0], 1'b1};
         end else begin
            rem_in = trial[KW-1:0];
            quo_in = {quo_ff[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= KW'(1);
         quo_ff <= RW'(1) << lcdab_pkg::RECIP_SHIFT;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else begin
         k_ff   <= k_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.busy  = (cnt_ff != '0);
   assign status.k     = k_ff;
   assign status.recip = quo_ff;

endmodule

@@ sv/lcd_afterimage_pixel_blend.sv @@
// LCD afterimage blend: each request names a pixel, a source intensity and a
// drive status (on: target = source, off: target = 0, reverse: target =
// 255 - source, status 3: not driven, the stored value is returned as is).
// The block reads the pixel's shown value from an on-chip store of
// DISPLAY_WIDTH*DISPLAY_HEIGHT bytes, writes back floor((target +
// shown*(k-1))/k) with k = decay_factor (0 acts as 1) and returns it.
// Positions off the display return 0 and leave the store alone. Six pipeline
// registers from request to response, one request per cycle when no stall
// holds the flow. A request whose pixel is still being updated by one of the
// three requests ahead of it in the read-modify-write path waits until that
// write lands. After reset the store is zeroed one entry per cycle, with
// req_stall high until the sweep ends. A decay_factor write starts a
// reciprocal computation, during which req_stall is high; configuration
// writes are expected only while no request is in flight.
module lcd_afterimage_pixel_blend #(
   parameter int DISPLAY_WIDTH  = 320,
   parameter int DISPLAY_HEIGHT = 240
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lcdab_pkg::PX_W-1:0]      req_pixel_x,
   input  logic [lcdab_pkg::PY_W-1:0]      req_pixel_y,
   input  logic [lcdab_pkg::VAL_W-1:0]     req_source_value,
   input  logic [lcdab_pkg::STAT_W-1:0]    req_drive_status,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lcdab_pkg::VAL_W-1:0]     rsp_shown_value,
   input  logic                            csr_write_enable,
   input  logic [lcdab_pkg::K_W-1:0]       csr_write_data
);

   localparam int DEPTH  = DISPLAY_WIDTH * DISPLAY_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int VW     = lcdab_pkg::VAL_W;
   localparam int SW     = lcdab_pkg::SUM_W;
   localparam int BW     = lcdab_pkg::BIG_W;
   localparam int CW     = lcdab_pkg::COORD_W;
   localparam int AC_W   = lcdab_pkg::ADDR_CALC_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [CW-1:0]     WIDTH_C   = CW'(DISPLAY_WIDTH);
   localparam logic [CW-1:0]     HEIGHT_C  = CW'(DISPLAY_HEIGHT);

   // per-request control that rides along stages 2 to 5
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              inr;   // position on the display
      logic              keep;  // not driven: return stored value
      logic              wr;    // updates the store
   } ctl_type;

   typedef struct packed {
      logic [lcdab_pkg::PX_W-1:0]   px;
      logic [lcdab_pkg::PY_W-1:0]   py;
      logic [VW-1:0]                src;
      logic [lcdab_pkg::STAT_W-1:0] stat;
   } s1_type;

   typedef struct packed {
      ctl_type       ctl;
      logic [VW-1:0] target;
   } s2_type;

   typedef struct packed {
      ctl_type       ctl;
      logic [VW-1:0] shown;
      logic [SW-1:0] n;
   } s4_type;

   typedef struct packed {
      ctl_type       ctl;
      logic [VW-1:0] shown;
      logic [BW-1:0] big;
   } s5_type;

   lcdab_pkg::div_status_type div;

   // ---------------------------------------------------------------------
   // pipeline registers
   // ---------------------------------------------------------------------
   logic   s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic   s4_v_ff, s4_v_in, s5_v_ff, s5_v_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s2_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff, rsp_value_in;

   // store clearing sweep after reset
   logic              clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // stage moves: item in stage N goes on at this edge
   logic go1, go2, go3, go4, go5;
   logic free1, free2, free3, free4, free5;
   logic out_free, accept, hazard;

   // stage 1 combinational
   logic [AC_W-1:0] addr_full;
   ctl_type         s1_ctl;
   logic [VW-1:0]   s1_target;

   // stage 3/5 combinational
   logic [VW-1:0]   ram_rd_data;
   logic [VW-1:0]   km1;
   logic [VW-1:0]   quot;
   logic [VW-1:0]   s5_value;

   // store ports
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [VW-1:0]     ram_wr_data;

   // ---------------------------------------------------------------------
   // flow control: each stage moves when the next one is empty or moving
   // ---------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go5      = s5_v_ff && out_free;
   assign free5    = !s5_v_ff || go5;
   assign go4      = s4_v_ff && free5;
   assign free4    = !s4_v_ff || go4;
   assign go3      = s3_v_ff && free4;
   assign free3    = !s3_v_ff || go3;

   // read-after-write interlock: hold a store read while a request ahead
   // of it still has to write the same pixel
   assign hazard = s2_ff.ctl.inr && (
                      (s3_v_ff && s3_ff.ctl.wr && (s3_ff.ctl.addr == s2_ff.ctl.addr)) ||
                      (s4_v_ff && s4_ff.ctl.wr && (s4_ff.ctl.addr == s2_ff.ctl.addr)) ||
                      (s5_v_ff && s5_ff.ctl.wr && (s5_ff.ctl.addr == s2_ff.ctl.addr)));

   assign go2   = s2_v_ff && free3 && !hazard;
   assign free2 = !s2_v_ff || go2;
   assign go1   = s1_v_ff && free2;
   assign free1 = !s1_v_ff || go1;

   assign req_stall = !free1 || clr_active_ff || div.busy;
   assign accept    = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // stage 1: address, range check, target
   // ---------------------------------------------------------------------
   always_comb begin
      addr_full     = AC_W'(s1_ff.py) * AC_W'(DISPLAY_WIDTH) + AC_W'(s1_ff.px);
      s1_ctl.addr   = addr_full[ADDR_W-1:0];
      s1_ctl.inr    = (CW'(s1_ff.px) < WIDTH_C) && (CW'(s1_ff.py) < HEIGHT_C);
      s1_ctl.keep   = (s1_ff.stat == lcdab_pkg::DRIVE_NONE);
      s1_ctl.wr     = s1_ctl.inr && !s1_ctl.keep;
      case (s1_ff.stat)
         lcdab_pkg::DRIVE_ON:      s1_target = s1_ff.src;
         lcdab_pkg::DRIVE_OFF:     s1_target = '0;
         lcdab_pkg::DRIVE_REVERSE: s1_target = lcdab_pkg::VAL_MAX - s1_ff.src;
         default:                  s1_target = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // stage 3: shown*(k-1) + target; stage 5: quotient by reciprocal
   // ---------------------------------------------------------------------
   assign km1  = div.k - VW'(1);
   assign quot = s5_ff.big[lcdab_pkg::RECIP_SHIFT +: VW];

   always_comb begin
      if (!s5_ff.ctl.inr) begin
         s5_value = '0;
      end else if (s5_ff.ctl.keep) begin
         s5_value = s5_ff.shown;
      end else begin
         s5_value = quot;
      end
   end

   // ---------------------------------------------------------------------
   // next-state for the pipeline
   // ---------------------------------------------------------------------
   always_comb begin
      s1_v_in = accept || (s1_v_ff && !go1);
      s1_in   = s1_ff;
      if (accept) begin
         s1_in.px   = req_pixel_x;
         s1_in.py   = req_pixel_y;
         s1_in.src  = req_source_value;
         s1_in.stat = req_drive_status;
      end

      s2_v_in = go1 || (s2_v_ff && !go2);
      s2_in   = s2_ff;
      if (go1) begin
         s2_in.ctl    = s1_ctl;
         s2_in.target = s1_target;
      end

      s3_v_in = go2 || (s3_v_ff && !go3);
      s3_in   = go2 ? s2_ff : s3_ff;

      s4_v_in = go3 || (s4_v_ff && !go4);
      s4_in   = s4_ff;
      if (go3) begin
         s4_in.ctl   = s3_ff.ctl;
         s4_in.shown = ram_rd_data;
         s4_in.n     = SW'(SW'(ram_rd_data) * SW'(km1)) + SW'(s3_ff.target);
      end

      s5_v_in = go4 || (s5_v_ff && !go5);
      s5_in   = s5_ff;
      if (go4) begin
         s5_in.ctl   = s4_ff.ctl;
         s5_in.shown = s4_ff.shown;
         s5_in.big   = BW'(BW'(s4_ff.n) * BW'(div.recip));
      end

      rsp_valid_in = go5 || (rsp_valid_ff && rsp_stall);
      rsp_value_in = go5 ? s5_value : rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         s4_v_ff      <= s4_v_in;
         s5_v_ff      <= s5_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      s3_ff        <= s3_in;
      s4_ff        <= s4_in;
      s5_ff        <= s5_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shown_value = rsp_value_ff;

   // ---------------------------------------------------------------------
   // clearing sweep: zero every store entry once after reset
   // ---------------------------------------------------------------------
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------------
   // shown-value store: read at stage 2 -> 3, write back from stage 5
   // (rewritten each cycle the item sits there, same value)
   // ---------------------------------------------------------------------
   assign ram_rd_en   = go2 && s2_ff.ctl.inr;
   assign ram_wr_en   = clr_active_ff || (s5_v_ff && s5_ff.ctl.wr);
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : s5_ff.ctl.addr;
   assign ram_wr_data = clr_active_ff ? '0 : quot;

   lcdab_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (s2_ff.ctl.addr),
      .rd_data (ram_rd_data)
   );

   // decay register and its reciprocal
   lcdab_recip u_recip (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (div)
   );

`ifndef NO_ASSERTIONS
   // interlock: a read never races a pending write-back of the same pixel
   a_no_raw_race: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && s5_v_ff && s5_ff.ctl.wr) |-> (s2_ff.ctl.addr != s5_ff.ctl.addr))
      else $error("store read issued against pending write of same pixel");

   // blended result always fits in a byte
   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      (s5_v_ff && s5_ff.ctl.wr) |-> (s5_ff.big[lcdab_pkg::RECIP_SHIFT + VW +: VW] == '0))
      else $error("blend quotient exceeds 8 bits");

   // off-display request answers zero
   a_off_zero: assert property (@(posedge clock) disable iff (reset)
      (go5 && !s5_ff.ctl.inr) |=> (rsp_shown_value == '0))
      else $error("off-display request returned nonzero");

   // sweep ends only after the last entry
   a_clr_done: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> ($past(clr_addr_ff) == LAST_ADDR))
      else $error("clearing sweep ended early");

   // nothing enters while the store clears or the reciprocal is computed
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (clr_active_ff || div.busy) |-> !accept)
      else $error("request accepted while block busy");
`endif

endmodule
